### src/hcsm_pkg.sv
// Shared widths, handshake structs and the commutation table of the hall speed meter.
`default_nettype none
package hcsm_pkg;

	parameter int EDGES_PER_AVERAGE_DEF = 12;
	parameter int STEPS_PER_CYCLE_DEF   = 6;

	// Operand and product widths of the shared multiplier.
	parameter int MUL_A_W = 32;
	parameter int MUL_B_W = 21;
	parameter int PROD_W  = MUL_A_W + MUL_B_W;

	// Divider widths: numerator, divisor, quotient and the shifted divisor.
	parameter int NUM_W  = 37;
	parameter int DEN_W  = 41;
	parameter int QUO_W  = 32;
	parameter int DSH_W  = DEN_W + 16;
	parameter int ITER_W = $clog2(QUO_W + 1);

	// Speed quotient is taken to 17 bits; a set top bit means saturation.
	parameter int SPEED_ITERS = 17;

	parameter logic [MUL_B_W-1:0] SPEED_SCALE = 21'd1200000;
	parameter logic [15:0]        SPEED_MAX   = 16'hFFFF;
	parameter logic [15:0]        TICK_MAX    = 16'hFFFF;

	parameter logic [1:0] REG_DIRECTION    = 2'd0;
	parameter logic [1:0] REG_POLE_PAIRS   = 2'd1;
	parameter logic [1:0] REG_TIMER_PERIOD = 2'd2;

	parameter logic [2:0] HALL_NONE_LOW  = 3'd0;
	parameter logic [2:0] HALL_NONE_HIGH = 3'd7;

	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] iters;
		logic [NUM_W-1:0]  num;
		logic [DSH_W-1:0]  dsh;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_sts_t;

	function automatic logic [11:0] gate_pattern(input logic fwd, input logic [2:0] hall);
		logic [11:0] pat;
		begin
			pat = 12'h000;
			case (hall)
				3'd1: pat = fwd ? 12'h7FD : 12'hD7F;
				3'd2: pat = fwd ? 12'hFD7 : 12'hF7D;
				3'd3: pat = fwd ? 12'h7DF : 12'hDF7;
				3'd4: pat = fwd ? 12'hD7F : 12'h7DF;
				3'd5: pat = fwd ? 12'hF7D : 12'hFD7;
				3'd6: pat = fwd ? 12'hDF7 : 12'h7FD;
				default: pat = 12'h000;
			endcase
			return pat;
		end
	endfunction

endpackage
`default_nettype wire

### src/hall_commutation_speed_meter_unit.sv
// Hall commutation: a tick is taken with no item out; an edge item is registered to the
// output through S_ACC and S_OUT, or, when it closes an averaging window, after two
// reciprocal and three plain products on the shared multiplier, then a 17-step speed
// division on the shared divider, which is skipped when that window's divisor is zero.
// One item is in work at a time; s_tready returns the cycle after the result is registered.
// Asynchronous active-low reset clears state and counters and loads the register defaults.
`default_nettype none
module hall_commutation_speed_meter_unit #(
	parameter int EDGES_PER_AVERAGE = hcsm_pkg::EDGES_PER_AVERAGE_DEF,
	parameter int STEPS_PER_CYCLE   = hcsm_pkg::STEPS_PER_CYCLE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // hall_state[2:0], timer_value[18:3], zero fill
	input  wire logic [0:0]  s_tuser,   // action[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // drive_pattern[11:0], speed[27:12], zero fill
	output logic      [1:0]  m_tuser,   // hall_invalid[0], speed_valid[1]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	localparam logic [5:0]  EDGE_LIMIT = 6'(EDGES_PER_AVERAGE);
	localparam logic [3:0]  STEPS      = 4'(STEPS_PER_CYCLE);
	// The window average is floor(sum * AVG_RECIP / 2^AVG_SHIFT), exact for any 32-bit sum.
	localparam int          AVG_SHIFT  = 32 + $clog2(EDGES_PER_AVERAGE);
	localparam logic [32:0] AVG_RECIP  = 33'(((64'd1 << AVG_SHIFT) +
		64'(EDGES_PER_AVERAGE) - 64'd1) / 64'(EDGES_PER_AVERAGE));

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_AVG_LO,
		S_AVG_HI,
		S_AVG_SUM,
		S_DEN_MUL,
		S_NUM_MUL,
		S_SPD_START,
		S_SPD_WAIT,
		S_OUT
	} state_t;

	state_t state_q;

	logic        direction_q;
	logic [4:0]  pole_pairs_q;
	logic [15:0] timer_period_q;

	logic [11:0] pattern_q;
	logic [15:0] tick_count_q;
	logic [31:0] time_sum_q;
	logic [5:0]  edge_count_q;
	logic [15:0] speed_q;

	logic [15:0] tval_q;
	logic        invalid_q;
	logic        win_q;
	// Holds the window sum until the average replaces it.
	logic [31:0] avg_q;
	logic [hcsm_pkg::PROD_W-1:0] lo_q;
	logic [hcsm_pkg::DEN_W-1:0] den_q;

	logic [11:0] out_pattern_q;
	logic        out_invalid_q;
	logic [15:0] out_speed_q;
	logic        out_win_q;
	logic        m_tvalid_q;

	logic [hcsm_pkg::MUL_A_W-1:0] mul_a;
	logic [hcsm_pkg::MUL_B_W-1:0] mul_b;
	logic [hcsm_pkg::PROD_W-1:0]  prod;

	hcsm_pkg::div_req_t div_req;
	hcsm_pkg::div_sts_t div_sts;

	logic        in_acc;
	logic [2:0]  in_hall;
	logic [31:0] sum_next;
	logic [5:0]  edge_next;
	logic        win_now;
	logic        out_free;
	logic [65:0] avg_full;
	logic [65:0] avg_shr;

	assign in_acc    = s_tvalid && s_tready;
	assign in_hall   = s_tdata[2:0];
	assign sum_next  = time_sum_q + prod[31:0] + 32'(tval_q);
	assign edge_next = edge_count_q + 6'd1;
	assign win_now   = (edge_next == EDGE_LIMIT);
	assign out_free  = !m_tvalid_q || m_tready;
	assign avg_full  = 66'(lo_q) + (66'(prod) << hcsm_pkg::MUL_B_W);
	assign avg_shr   = avg_full >> AVG_SHIFT;

	hcsm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	hcsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	// Operand selection for the shared multiplier; in idle it forms period * ticks.
	always_comb begin
		mul_a = hcsm_pkg::MUL_A_W'(tick_count_q);
		mul_b = hcsm_pkg::MUL_B_W'(timer_period_q);
		case (state_q)
			S_AVG_LO: begin
				mul_a = avg_q;
				mul_b = AVG_RECIP[hcsm_pkg::MUL_B_W-1:0];
			end
			S_AVG_HI: begin
				mul_a = avg_q;
				mul_b = hcsm_pkg::MUL_B_W'(AVG_RECIP[32:hcsm_pkg::MUL_B_W]);
			end
			S_AVG_SUM: begin
				mul_a = hcsm_pkg::MUL_A_W'(STEPS);
				mul_b = hcsm_pkg::MUL_B_W'(pole_pairs_q);
			end
			S_DEN_MUL: begin
				mul_a = avg_q;
				mul_b = prod[hcsm_pkg::MUL_B_W-1:0];
			end
			S_NUM_MUL: begin
				mul_a = hcsm_pkg::MUL_A_W'(timer_period_q);
				mul_b = hcsm_pkg::SPEED_SCALE;
			end
			default: begin
				mul_a = hcsm_pkg::MUL_A_W'(tick_count_q);
				mul_b = hcsm_pkg::MUL_B_W'(timer_period_q);
			end
		endcase
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.iters = hcsm_pkg::ITER_W'(hcsm_pkg::SPEED_ITERS);
		div_req.num   = prod[hcsm_pkg::NUM_W-1:0];
		div_req.dsh   = {den_q, 16'h0000};
		case (state_q)
			S_SPD_START: begin
				div_req.start = (den_q != '0);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			direction_q    <= 1'b1;
			pole_pairs_q   <= 5'd2;
			timer_period_q <= 16'd117;
			pattern_q      <= '0;
			tick_count_q   <= '0;
			time_sum_q     <= '0;
			edge_count_q   <= '0;
			speed_q        <= '0;
			m_tvalid_q     <= 1'b0;
			win_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hcsm_pkg::REG_DIRECTION:    direction_q    <= cfg_wdata[0];
					hcsm_pkg::REG_POLE_PAIRS:   pole_pairs_q   <= cfg_wdata[4:0];
					hcsm_pkg::REG_TIMER_PERIOD: timer_period_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!s_tuser[0]) begin
							if (tick_count_q != hcsm_pkg::TICK_MAX) begin
								tick_count_q <= tick_count_q + 16'd1;
							end
						end else begin
							tval_q <= s_tdata[18:3];
							if (in_hall == hcsm_pkg::HALL_NONE_LOW ||
							    in_hall == hcsm_pkg::HALL_NONE_HIGH) begin
								invalid_q <= 1'b1;
							end else begin
								invalid_q <= 1'b0;
								pattern_q <= hcsm_pkg::gate_pattern(direction_q, in_hall);
							end
							state_q <= S_ACC;
						end
					end
				end
				S_ACC: begin
					tick_count_q <= '0;
					win_q        <= win_now;
					if (win_now) begin
						avg_q        <= sum_next;
						time_sum_q   <= '0;
						edge_count_q <= '0;
						state_q      <= S_AVG_LO;
					end else begin
						time_sum_q   <= sum_next;
						edge_count_q <= edge_next;
						state_q      <= S_OUT;
					end
				end
				S_AVG_LO: begin
					state_q <= S_AVG_HI;
				end
				S_AVG_HI: begin
					lo_q    <= prod;
					state_q <= S_AVG_SUM;
				end
				S_AVG_SUM: begin
					avg_q   <= avg_shr[31:0];
					state_q <= S_DEN_MUL;
				end
				S_DEN_MUL: begin
					state_q <= S_NUM_MUL;
				end
				S_NUM_MUL: begin
					den_q   <= prod[hcsm_pkg::DEN_W-1:0];
					state_q <= S_SPD_START;
				end
				S_SPD_START: begin
					// A zero divisor means the motor reads as fast as can be shown.
					if (den_q == '0) begin
						speed_q <= hcsm_pkg::SPEED_MAX;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SPD_WAIT;
					end
				end
				S_SPD_WAIT: begin
					if (div_sts.done) begin
						speed_q <= div_sts.quo[hcsm_pkg::SPEED_ITERS-1] ?
						           hcsm_pkg::SPEED_MAX : div_sts.quo[15:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_pattern_q <= pattern_q;
						out_invalid_q <= invalid_q;
						out_speed_q   <= speed_q;
						out_win_q     <= win_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'h0, out_speed_q, out_pattern_q};
	assign m_tuser  = {out_win_q, out_invalid_q};

	a_edge_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q < EDGE_LIMIT)
		else $error("edge count reached the window length");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == S_SPD_WAIT))
		else $error("divider finished outside a waiting state");

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_sts.busy)
		else $error("input ready while the divider is busy");

	a_tick_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !s_tuser[0]) |=> state_q == S_IDLE)
		else $error("tick item started the edge sequence");

	a_tick_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |=> tick_count_q == '0)
		else $error("tick count not cleared by an edge");

endmodule
`default_nettype wire

### src/hcsm_mul.sv
// Shared registered multiplier used by every product of the speed meter.
`default_nettype none
module hcsm_mul (
	input  wire logic                        clk,
	input  wire logic [hcsm_pkg::MUL_A_W-1:0] a,
	input  wire logic [hcsm_pkg::MUL_B_W-1:0] b,
	output logic      [hcsm_pkg::PROD_W-1:0]  p_q
);

	always_ff @(posedge clk) begin
		p_q <= hcsm_pkg::PROD_W'(a) * hcsm_pkg::PROD_W'(b);
	end

endmodule
`default_nettype wire

### src/hcsm_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module hcsm_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hcsm_pkg::div_req_t req,
	output hcsm_pkg::div_sts_t      sts
);

	logic [hcsm_pkg::NUM_W-1:0]  rem_q;
	logic [hcsm_pkg::DSH_W-1:0]  dsh_q;
	logic [hcsm_pkg::QUO_W-1:0]  quo_q;
	logic [hcsm_pkg::ITER_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        ge;

	assign ge = hcsm_pkg::DSH_W'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == hcsm_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= req.dsh;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[hcsm_pkg::NUM_W-1:0];
			end
			quo_q <= {quo_q[hcsm_pkg::QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.quo  = quo_q;

endmodule
`default_nettype wire
